[src/rpdp_pkg.sv]
// Shared types, constants and helper functions of the random projection engine.
package rpdp_pkg;

  localparam int DefNumSpaces   = 4;
  localparam int DefProjPerSpace = 8;
  localparam int DefMaxDim      = 256;

  localparam int AccCount  = 8;
  localparam int CfgW      = 4;
  localparam int SpaceW    = 2;
  localparam int ProjW     = 3;
  localparam int ElemW     = 8;
  localparam int ValueW    = 16;
  localparam int ProdW     = 32;
  localparam int AccW      = 48;
  localparam int IndexW    = 5;
  localparam int CntW      = 3;

  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  localparam logic OpLoad = 1'b0;
  localparam logic OpDesc = 1'b1;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef struct packed {
    logic add;
    logic clear;
  } mac_ctrl_t;

  function automatic logic [CfgW-1:0] active_count(logic [CfgW-1:0] cfg, int lim);
    logic [CfgW-1:0] n;
    n = cfg;
    if (n == '0) begin
      n = CfgW'(1);
    end
    if (32'(n) > lim) begin
      n = CfgW'(lim);
    end
    return n;
  endfunction

endpackage

[src/rpdp_wmem.sv]
// Banked weight memory, one synchronous bank per projector lane.
module rpdp_wmem #(
  parameter int Lanes = 8,
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [rpdp_pkg::ProjW-1:0]               wlane_i,
  input  logic [AddrW-1:0]                         waddr_i,
  input  logic [rpdp_pkg::ValueW-1:0]              wdata_i,
  input  logic                                     re_i,
  input  logic [AddrW-1:0]                         raddr_i,
  output logic [Lanes-1:0][rpdp_pkg::ValueW-1:0]   rdata_o
);

  for (genvar g = 0; g < Lanes; g++) begin : g_bank
    logic [rpdp_pkg::ValueW-1:0] mem [Depth];
    logic [rpdp_pkg::ValueW-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wlane_i == rpdp_pkg::ProjW'(g))) begin
        mem[waddr_i] <= wdata_i;
      end
      if (re_i) begin
        rdata_q <= mem[raddr_i];
      end
    end

    assign rdata_o[g] = rdata_q;
  end

endmodule

[src/rpdp_mac.sv]
// Parallel multipliers and saturating accumulators, one per projector lane.
module rpdp_mac #(
  parameter int Lanes = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  rpdp_pkg::mac_ctrl_t                           ctrl_i,
  input  logic [Lanes-1:0][rpdp_pkg::ValueW-1:0]        weight_i,
  input  logic signed [rpdp_pkg::ValueW-1:0]            value_i,
  input  logic [rpdp_pkg::CfgW-1:0]                     active_i,
  output logic [Lanes-1:0][rpdp_pkg::AccW-1:0]          acc_o
);

  logic add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
    end else begin
      add_q <= ctrl_i.add;
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    logic signed [rpdp_pkg::ProdW-1:0] prod_q;
    logic signed [rpdp_pkg::AccW-1:0]  acc_q;
    logic signed [rpdp_pkg::AccW:0]    sum;
    logic signed [rpdp_pkg::AccW-1:0]  acc_d;

    always_ff @(posedge clk_i) begin
      if (ctrl_i.add) begin
        prod_q <= $signed(weight_i[g]) * value_i;
      end
    end

    always_comb begin
      sum = {acc_q[rpdp_pkg::AccW-1], acc_q}
            + (rpdp_pkg::AccW+1)'(prod_q);
      if (sum[rpdp_pkg::AccW] != sum[rpdp_pkg::AccW-1]) begin
        acc_d = sum[rpdp_pkg::AccW] ? rpdp_pkg::AccMin : rpdp_pkg::AccMax;
      end else begin
        acc_d = sum[rpdp_pkg::AccW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q <= '0;
      end else if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (add_q && (32'(active_i) > g)) begin
        acc_q <= acc_d;
      end
    end

    assign acc_o[g] = acc_q;
  end

endmodule

[src/random_projection_dot_product_top.sv]
// Top level of the random projection engine: input decode, pipeline and result sequencer.
//
// A word is accepted at a rising edge with start high and busy low. A load word
// (opcode 0) writes one Q1.15 weight into the banked weight memory; a descriptor
// word (opcode 1) reads one weight per projector lane, multiplies each by the
// Q8.8 element and adds the Q9.23 products into saturating 48-bit accumulators.
// Load and descriptor words enter at one per cycle while busy is low; the pipeline is memory read,
// multiply, accumulate.
// A descriptor word marked last_element raises busy at once. After last1_q,
// last2_q, the emit state and the output registers the first result is on the
// ports, then one result per cycle for each active projector, with last_o on
// the final one. busy falls with the final result, which closes the space.
// Each result is shown for exactly one cycle under result_strobe_o; the receiver
// cannot hold it off. The configuration channel is always ready and takes the
// projector count; write it only while the block is idle.
// Reset clears the accumulators and sets the projector count to eight; the
// weight memory is undefined until loaded.
module random_projection_dot_product_top #(
  parameter int NUM_SPACES     = rpdp_pkg::DefNumSpaces,
  parameter int PROJ_PER_SPACE = rpdp_pkg::DefProjPerSpace,
  parameter int MAX_DIM        = rpdp_pkg::DefMaxDim
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode_i,
  input  logic [rpdp_pkg::SpaceW-1:0]        space_i,
  input  logic [rpdp_pkg::ProjW-1:0]         projector_i,
  input  logic [rpdp_pkg::ElemW-1:0]         element_i,
  input  logic signed [rpdp_pkg::ValueW-1:0] value_i,
  input  logic                               last_element_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rpdp_pkg::CfgW-1:0]          cfg_data_i,
  output logic                               result_strobe_o,
  output logic [rpdp_pkg::IndexW-1:0]        index_o,
  output logic signed [rpdp_pkg::AccW-1:0]   projection_o,
  output logic                               last_o
);

  localparam int Lanes  = (PROJ_PER_SPACE < rpdp_pkg::AccCount) ? PROJ_PER_SPACE
                                                                : rpdp_pkg::AccCount;
  localparam int NsEff  = (NUM_SPACES < 4) ? NUM_SPACES : 4;
  localparam int DimEff = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam int Depth  = NsEff * DimEff;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic {
    S_RUN,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [rpdp_pkg::CfgW-1:0]       cfg_q;
  logic [rpdp_pkg::CfgW-1:0]       active;
  logic                            accept;
  logic                            space_ok;
  logic                            elem_ok;
  logic                            desc_ok;
  logic                            load_ok;
  logic [31:0]                     addr_full;
  logic [AddrW-1:0]                addr;

  logic                            add1_q;
  logic                            last1_q;
  logic                            last2_q;
  logic signed [rpdp_pkg::ValueW-1:0] val1_q;
  logic [rpdp_pkg::SpaceW-1:0]     sp_last_q;

  logic [rpdp_pkg::CntW-1:0]       cnt_q;
  logic                            busy_q;
  logic                            strobe_q;
  logic [rpdp_pkg::IndexW-1:0]     index_q;
  logic signed [rpdp_pkg::AccW-1:0] proj_q;
  logic                            last_q;

  logic [Lanes-1:0][rpdp_pkg::ValueW-1:0] rdata;
  logic [Lanes-1:0][rpdp_pkg::AccW-1:0]   acc;
  logic [rpdp_pkg::AccW-1:0]              acc_all [rpdp_pkg::AccCount];
  rpdp_pkg::mac_ctrl_t                    mac_ctrl;
  logic                                   emit_end;
  logic [5:0]                             index_full;

  assign accept      = start && !busy_q;
  assign active      = rpdp_pkg::active_count(cfg_q, Lanes);
  assign space_ok    = 32'(space_i) < NUM_SPACES;
  assign elem_ok     = 32'(element_i) < MAX_DIM;
  assign desc_ok     = accept && (opcode_i == rpdp_pkg::OpDesc) && space_ok;
  assign load_ok     = accept && (opcode_i == rpdp_pkg::OpLoad) && space_ok && elem_ok
                       && (32'(projector_i) < PROJ_PER_SPACE);
  assign addr_full   = 32'(space_i) * 32'(DimEff) + 32'(element_i);
  assign addr        = addr_full[AddrW-1:0];
  assign emit_end    = (state_q == S_EMIT) && (4'(cnt_q) + 4'd1 == active);
  assign index_full  = 6'(sp_last_q) * 6'(active) + 6'(cnt_q);

  assign mac_ctrl.add   = add1_q;
  assign mac_ctrl.clear = emit_end;

  for (genvar g = 0; g < rpdp_pkg::AccCount; g++) begin : g_pad
    if (g < Lanes) begin : g_real
      assign acc_all[g] = acc[g];
    end else begin : g_zero
      assign acc_all[g] = '0;
    end
  end

  rpdp_wmem #(
    .Lanes (Lanes),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_wmem (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .wlane_i (projector_i),
    .waddr_i (addr),
    .wdata_i (value_i),
    .re_i    (desc_ok),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  rpdp_mac #(
    .Lanes (Lanes)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .weight_i (rdata),
    .value_i  (val1_q),
    .active_i (active),
    .acc_o    (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rpdp_pkg::CfgReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add1_q    <= 1'b0;
      last1_q   <= 1'b0;
      last2_q   <= 1'b0;
      val1_q    <= '0;
      sp_last_q <= '0;
    end else begin
      add1_q  <= desc_ok && elem_ok;
      last1_q <= desc_ok && last_element_i;
      last2_q <= last1_q;
      if (desc_ok) begin
        val1_q <= value_i;
      end
      if (desc_ok && last_element_i) begin
        sp_last_q <= space_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RUN;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      strobe_q <= 1'b0;
      index_q  <= '0;
      proj_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      if (desc_ok && last_element_i) begin
        busy_q <= 1'b1;
      end
      unique case (state_q)
        S_RUN: begin
          cnt_q <= '0;
          if (last2_q) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe_q <= 1'b1;
          index_q  <= index_full[rpdp_pkg::IndexW-1:0];
          proj_q   <= acc_all[cnt_q];
          last_q   <= emit_end;
          cnt_q    <= cnt_q + 1'b1;
          if (emit_end) begin
            state_q <= S_RUN;
            busy_q  <= 1'b0;
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

  assign busy            = busy_q;
  assign cfg_ready_o     = 1'b1;
  assign result_strobe_o = strobe_q;
  assign index_o         = index_q;
  assign projection_o    = proj_q;
  assign last_o          = last_q;

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> busy_q)
    else $error("Result sequencer runs while new words are accepted.");

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == S_EMIT))
    else $error("Result strobe without a preceding emit cycle.");

  a_mid_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |-> busy_q)
    else $error("Busy dropped before the final result of a burst.");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_o) |-> (!busy_q && (state_q == S_RUN)))
    else $error("Final result did not release the engine.");

  a_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_o) |-> $past(mac_ctrl.clear))
    else $error("Accumulators not cleared with the final result.");

endmodule
